FILE: hw/rtl/clws_pkg.sv
package clws_pkg;

  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_CMD    = 3'd1,
    OP_CHAR   = 3'd2,
    OP_GOTO   = 3'd3,
    OP_SHIFT  = 3'd4,
    OP_CLEAR  = 3'd5,
    OP_NUMBER = 3'd6
  } opcode_e;

  typedef enum logic [1:0] {
    WAIT_NONE  = 2'd0,
    WAIT_45    = 2'd1,
    WAIT_2000  = 2'd2,
    WAIT_10000 = 2'd3
  } wait_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SEQ,
    F_CONV,
    F_DIGITS
  } front_state_e;

  // One byte (or the lone init nibble) queued for the pulse generator.
  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic       single;
    logic       wait_init;
    wait_e      wait_after;
    logic       last;
  } clws_entry_t;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [15:0] WAIT_INIT_US    = 16'd35000;
  localparam logic [13:0] WAIT_45_US      = 14'd45;
  localparam logic [13:0] WAIT_2000_US    = 14'd2000;
  localparam logic [13:0] WAIT_10000_US   = 14'd10000;

  localparam logic [7:0] CMD_FSET_8      = 8'b0011_1000;
  localparam logic [7:0] CMD_FSET_4      = 8'b0010_1000;
  localparam logic [7:0] CMD_DISPLAY_ON  = 8'b0000_1111;
  localparam logic [7:0] CMD_CLEAR       = 8'b0000_0001;
  localparam logic [7:0] CMD_ENTRY_MODE  = 8'b0000_0110;
  localparam logic [3:0] DDRAM_LINE0_HI  = 4'h8;
  localparam logic [3:0] DDRAM_LINE1_HI  = 4'hC;
  localparam logic [7:0] CMD_SHIFT_LEFT  = 8'b0001_1000;
  localparam logic [7:0] CMD_SHIFT_RIGHT = 8'b0001_1100;
  localparam logic [7:0] NIB_INIT_4BIT   = 8'b0000_0010;
  localparam logic [7:0] MAX_COLUMN      = 8'd15;
  localparam logic [3:0] ASCII_DIGIT_HI  = 4'h3;

endpackage

FILE: hw/rtl/clws_front.sv
module clws_front
  import clws_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  value_i,
  input  logic        line_i,
  input  logic [7:0]  column_i,
  input  logic        direction_i,
  input  logic [31:0] number_i,
  input  logic        bus_mode_i,
  input  logic        full_i,
  output logic        busy_o,
  output logic        push_o,
  output clws_entry_t push_data_o
);

  front_state_e     state_q, state_d;
  logic [2:0]       op_q, op_d;
  logic [7:0]       value_q, value_d;
  logic             line_q, line_d;
  logic [3:0]       col_q, col_d;
  logic             dir_q, dir_d;
  logic [2:0]       step_q, step_d;
  logic [31:0]      bin_q, bin_d;
  logic [9:0][3:0]  bcd_q, bcd_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [3:0]       dig_q, dig_d;
  logic             lead_q, lead_d;
  clws_entry_t      seq_entry;

  function automatic clws_entry_t seq_lookup(logic [2:0] op, logic [2:0] step, logic mode,
                                              logic [7:0] value, logic line, logic [3:0] col,
                                              logic dir);
    clws_entry_t e;
    logic [2:0]  idx;
    e = '0;
    e.wait_after = WAIT_NONE;
    idx = step + {2'b00, ~mode};
    unique case (op)
      OP_INIT: begin
        // The 4-bit bus starts with a lone nibble; the 8-bit bus skips that step.
        unique case (idx)
          3'd0: begin
            e.data      = NIB_INIT_4BIT;
            e.single    = 1'b1;
            e.wait_init = 1'b1;
          end
          3'd1: begin
            e.data       = mode ? CMD_FSET_4 : CMD_FSET_8;
            e.wait_init  = ~mode;
            e.wait_after = WAIT_45;
          end
          3'd2: begin
            e.data       = CMD_DISPLAY_ON;
            e.wait_after = WAIT_45;
          end
          3'd3: begin
            e.data       = CMD_CLEAR;
            e.wait_after = WAIT_2000;
          end
          default: begin
            e.data = CMD_ENTRY_MODE;
            e.last = 1'b1;
          end
        endcase
      end
      OP_CMD: begin
        e.data = value;
        e.last = 1'b1;
      end
      OP_CHAR: begin
        e.rs   = 1'b1;
        e.data = value;
        e.last = 1'b1;
      end
      OP_GOTO: begin
        e.data = {line ? DDRAM_LINE1_HI : DDRAM_LINE0_HI, col};
        e.last = 1'b1;
      end
      OP_SHIFT: begin
        e.data       = dir ? CMD_SHIFT_RIGHT : CMD_SHIFT_LEFT;
        e.wait_after = WAIT_10000;
        e.last       = 1'b1;
      end
      OP_CLEAR: begin
        e.data       = CMD_CLEAR;
        e.wait_after = WAIT_2000;
        e.last       = 1'b1;
      end
      default: begin
        e.last = 1'b1;
      end
    endcase
    return e;
  endfunction

  // One shift-add-3 step of the binary to BCD conversion.
  function automatic logic [9:0][3:0] dabble(logic [9:0][3:0] bcd, logic bit_in);
    logic [9:0][3:0] adj;
    logic [39:0]     flat;
    for (int i = 0; i < 10; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
    flat = adj;
    return {flat[38:0], bit_in};
  endfunction

  assign seq_entry = seq_lookup(op_q, step_q, bus_mode_i, value_q, line_q, col_q, dir_q);
  assign busy_o    = (state_q != F_IDLE);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    value_d     = value_q;
    line_d      = line_q;
    col_d       = col_q;
    dir_d       = dir_q;
    step_d      = step_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    dig_d       = dig_q;
    lead_d      = lead_q;
    push_o      = 1'b0;
    push_data_o = seq_entry;
    unique case (state_q)
      F_IDLE: begin
        if (start_i) begin
          op_d    = opcode_i;
          value_d = value_i;
          line_d  = line_i;
          col_d   = column_i[3:0];
          dir_d   = direction_i;
          step_d  = '0;
          case (opcode_i) inside
            OP_NUMBER: begin
              bin_d   = number_i;
              bcd_d   = '0;
              cnt_d   = '0;
              state_d = F_CONV;
            end
            OP_GOTO: begin
              if (column_i <= MAX_COLUMN) state_d = F_SEQ;
            end
            OP_INIT, OP_CMD, OP_CHAR, OP_SHIFT, OP_CLEAR: begin
              state_d = F_SEQ;
            end
            default: ;
          endcase
        end
      end
      F_SEQ: begin
        if (!full_i) begin
          push_o = 1'b1;
          if (seq_entry.last) begin
            state_d = F_IDLE;
          end else begin
            step_d = step_q + 3'd1;
          end
        end
      end
      F_CONV: begin
        bcd_d = dabble(bcd_q, bin_q[31]);
        bin_d = {bin_q[30:0], 1'b0};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          dig_d   = 4'd9;
          lead_d  = 1'b1;
          state_d = F_DIGITS;
        end
      end
      F_DIGITS: begin
        push_data_o            = '0;
        push_data_o.rs         = 1'b1;
        push_data_o.data       = {ASCII_DIGIT_HI, bcd_q[dig_q]};
        push_data_o.wait_after = WAIT_NONE;
        push_data_o.last       = (dig_q == 4'd0);
        // Leading zeros are skipped one digit per cycle; the ones digit always prints.
        if (lead_q && (bcd_q[dig_q] == 4'd0) && (dig_q != 4'd0)) begin
          dig_d = dig_q - 4'd1;
        end else if (!full_i) begin
          push_o = 1'b1;
          lead_d = 1'b0;
          if (dig_q == 4'd0) begin
            state_d = F_IDLE;
          end else begin
            dig_d = dig_q - 4'd1;
          end
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
      dig_q   <= '0;
      lead_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
      dig_q   <= dig_d;
      lead_q  <= lead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    value_q <= value_d;
    line_q  <= line_d;
    col_q   <= col_d;
    dir_q   <= dir_d;
    bin_q   <= bin_d;
    bcd_q   <= bcd_d;
  end

endmodule

FILE: hw/rtl/clws_fifo.sv
module clws_fifo
  import clws_pkg::*;
#(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  clws_entry_t push_data_i,
  input  logic        pop_i,
  output clws_entry_t head_o,
  output logic        full_o,
  output logic        empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  clws_entry_t     slot_q [Depth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [AW:0]     count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == (AW + 1)'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + (AW + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (AW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/clws_back.sv
module clws_back
  import clws_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        bus_mode_i,
  input  clws_entry_t head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        valid_o,
  output logic        reg_select_o,
  output logic [7:0]  bus_value_o,
  output logic [15:0] wait_before_us_o,
  output logic [13:0] wait_after_us_o,
  output logic        last_o
);

  logic        half_q, half_d;
  clws_entry_t held_q, held_d;
  logic        valid_q, valid_d;
  logic        rs_q, rs_d;
  logic [7:0]  bus_q, bus_d;
  logic [15:0] wb_q, wb_d;
  logic [13:0] wa_q, wa_d;
  logic        last_q, last_d;

  function automatic logic [13:0] wait_us(wait_e code);
    logic [13:0] us;
    unique case (code)
      WAIT_45:    us = WAIT_45_US;
      WAIT_2000:  us = WAIT_2000_US;
      WAIT_10000: us = WAIT_10000_US;
      default:    us = '0;
    endcase
    return us;
  endfunction

  assign pop_o = !half_q && !empty_i;

  always_comb begin
    half_d  = 1'b0;
    held_d  = held_q;
    valid_d = 1'b0;
    rs_d    = rs_q;
    bus_d   = bus_q;
    wb_d    = wb_q;
    wa_d    = wa_q;
    last_d  = 1'b0;
    if (half_q) begin
      // Low nibble of a byte on the 4-bit bus closes out that byte.
      valid_d = 1'b1;
      rs_d    = held_q.rs;
      bus_d   = {4'h0, held_q.data[3:0]};
      wb_d    = '0;
      wa_d    = wait_us(held_q.wait_after);
      last_d  = held_q.last;
    end else if (!empty_i) begin
      valid_d = 1'b1;
      rs_d    = head_i.rs;
      wb_d    = head_i.wait_init ? WAIT_INIT_US : '0;
      if (bus_mode_i && !head_i.single) begin
        held_d = head_i;
        half_d = 1'b1;
        bus_d  = {4'h0, head_i.data[7:4]};
        wa_d   = '0;
        last_d = 1'b0;
      end else begin
        bus_d  = head_i.data;
        wa_d   = wait_us(head_i.wait_after);
        last_d = head_i.last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= 1'b0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      half_q  <= half_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    rs_q   <= rs_d;
    bus_q  <= bus_d;
    wb_q   <= wb_d;
    wa_q   <= wa_d;
  end

  assign valid_o          = valid_q;
  assign reg_select_o     = rs_q;
  assign bus_value_o      = bus_q;
  assign wait_before_us_o = wb_q;
  assign wait_after_us_o  = wa_q;
  assign last_o           = last_q;

  a_nibble_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> valid_o && !last_o && (wait_after_us_o == '0) && (bus_value_o[7:4] == 4'h0))
    else $error("high nibble pulse not emitted as a non-final pulse");

  a_low_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |=> valid_o && !half_q && (wait_before_us_o == '0))
    else $error("low nibble did not follow its high nibble");

  a_init_wait_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (wait_before_us_o != '0) |-> !reg_select_o && !last_o)
    else $error("power-up wait on a data or final pulse");

endmodule

FILE: hw/rtl/char_lcd_write_sequencer_unit.sv
// Character-LCD write sequencer. Each operation taken on start_i becomes a run of
// enable-pulse descriptors on valid_o, one per cycle while any are queued, with
// last_o on the final one; the wait fields are for the downstream display timer.
// The receiver cannot stall: every valid_o cycle is one transfer and must be taken.
// A byte is one pulse on the 8-bit bus and two on the 4-bit bus (high nibble first).
// The front end holds busy_o while it expands an operation into bytes: fixed sequences
// are pushed byte by byte, and a number is converted from 32-bit binary to BCD and
// then walked over its ten digit positions from the top, skipping leading zeros.
// Whenever the byte queue is full, a byte push waits until there is room.
// The pulse stage drains that queue at one pulse per cycle while it holds entries, and
// a run of at most twenty pulses overlaps the front end's work.
// bus_mode may only be written while no operation is in flight.
module char_lcd_write_sequencer_unit
  import clws_pkg::*;
#(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  value_i,
  input  logic        line_i,
  input  logic [7:0]  column_i,
  input  logic        direction_i,
  input  logic [31:0] number_i,
  output logic        valid_o,
  output logic        reg_select_o,
  output logic [7:0]  bus_value_o,
  output logic [15:0] wait_before_us_o,
  output logic [13:0] wait_after_us_o,
  output logic        last_o
);

  logic        bus_mode_q;
  logic        push;
  clws_entry_t push_data;
  clws_entry_t head;
  logic        pop;
  logic        full;
  logic        empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      bus_mode_q <= cfg_wdata_i;
    end
  end

  clws_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .line_i      (line_i),
    .column_i    (column_i),
    .direction_i (direction_i),
    .number_i    (number_i),
    .bus_mode_i  (bus_mode_q),
    .full_i      (full),
    .busy_o      (busy_o),
    .push_o      (push),
    .push_data_o (push_data)
  );

  clws_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty)
  );

  clws_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .bus_mode_i       (bus_mode_q),
    .head_i           (head),
    .empty_i          (empty),
    .pop_o            (pop),
    .valid_o          (valid_o),
    .reg_select_o     (reg_select_o),
    .bus_value_o      (bus_value_o),
    .wait_before_us_o (wait_before_us_o),
    .wait_after_us_o  (wait_after_us_o),
    .last_o           (last_o)
  );

endmodule
